@@ hdl/aip_pkg.sv @@
`timescale 1ns / 1ps

package aip_pkg;

	// default widths of the result fields
	localparam int unsigned DEF_VALUE_WIDTH  = 64;
	localparam int unsigned DEF_OFFSET_WIDTH = 16;

	// fixed field and register widths
	localparam int unsigned CHAR_WIDTH      = 8;
	localparam int unsigned RADIX_WIDTH     = 5;
	localparam int unsigned MODE_WIDTH      = 2;
	localparam int unsigned DIGIT_WIDTH     = 4;
	localparam int unsigned SHIFT_WIDTH     = 5;
	localparam int unsigned CFG_INDEX_WIDTH = 1;
	localparam int unsigned CFG_DATA_WIDTH  = RADIX_WIDTH;

	// register indexes
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_RADIX = 1'd0;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_MODE  = 1'd1;

	// parse modes
	localparam logic [MODE_WIDTH-1:0] MODE_UNSIGNED = 2'd0;
	localparam logic [MODE_WIDTH-1:0] MODE_SIGNED   = 2'd1;
	localparam logic [MODE_WIDTH-1:0] MODE_SUFFIX   = 2'd2;

	// bases
	localparam logic [RADIX_WIDTH-1:0] BASE_AUTO = 5'd0;
	localparam logic [RADIX_WIDTH-1:0] BASE_OCT  = 5'd8;
	localparam logic [RADIX_WIDTH-1:0] BASE_DEC  = 5'd10;
	localparam logic [RADIX_WIDTH-1:0] BASE_HEX  = 5'd16;

	// size suffix shifts: 1024, 1024^2, 1024^3
	localparam logic [SHIFT_WIDTH-1:0] SHIFT_NONE = 5'd0;
	localparam logic [SHIFT_WIDTH-1:0] SHIFT_KILO = 5'd10;
	localparam logic [SHIFT_WIDTH-1:0] SHIFT_MEGA = 5'd20;
	localparam logic [SHIFT_WIDTH-1:0] SHIFT_GIGA = 5'd30;

	// characters
	localparam logic [CHAR_WIDTH-1:0] CH_ZERO    = 8'h30;
	localparam logic [CHAR_WIDTH-1:0] CH_NINE    = 8'h39;
	localparam logic [CHAR_WIDTH-1:0] CH_UPPER_A = 8'h41;
	localparam logic [CHAR_WIDTH-1:0] CH_UPPER_B = 8'h42;
	localparam logic [CHAR_WIDTH-1:0] CH_UPPER_Z = 8'h5a;
	localparam logic [CHAR_WIDTH-1:0] CH_LOWER_A = 8'h61;
	localparam logic [CHAR_WIDTH-1:0] CH_LOWER_F = 8'h66;
	localparam logic [CHAR_WIDTH-1:0] CH_LOWER_G = 8'h67;
	localparam logic [CHAR_WIDTH-1:0] CH_LOWER_I = 8'h69;
	localparam logic [CHAR_WIDTH-1:0] CH_LOWER_K = 8'h6b;
	localparam logic [CHAR_WIDTH-1:0] CH_LOWER_M = 8'h6d;
	localparam logic [CHAR_WIDTH-1:0] CH_LOWER_X = 8'h78;
	localparam logic [CHAR_WIDTH-1:0] CH_MINUS   = 8'h2d;
	localparam logic [CHAR_WIDTH-1:0] CASE_GAP   = 8'h20;
	localparam logic [CHAR_WIDTH-1:0] HEX_LETTER_BIAS = 8'h0a;

	// parser phases
	typedef enum logic [2:0] {
		PH_IDLE,
		PH_FIRST,
		PH_ZERO,
		PH_ZEROX,
		PH_DIGITS,
		PH_SUF1,
		PH_SUF2
	} phase_t;

	// where the end offset sits relative to the current character
	typedef enum logic [1:0] {
		END_AT,
		END_BEFORE,
		END_AFTER
	} end_sel_t;

	typedef struct packed {
		logic                   ok;
		logic [DIGIT_WIDTH-1:0] val;
	} digit_t;

	function automatic logic [CHAR_WIDTH-1:0] to_lower(input logic [CHAR_WIDTH-1:0] c);
		logic [CHAR_WIDTH-1:0] r;
		r = c;
		if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
			r = c + CASE_GAP;
		end
		return r;
	endfunction

	// hex digit value of a character, either case
	function automatic digit_t digit_of(input logic [CHAR_WIDTH-1:0] c);
		logic [CHAR_WIDTH-1:0] l;
		logic [CHAR_WIDTH-1:0] t;
		digit_t                d;
		l = to_lower(c);
		t = '0;
		d.ok  = 1'b0;
		d.val = '0;
		if (l >= CH_ZERO && l <= CH_NINE) begin
			t     = l - CH_ZERO;
			d.ok  = 1'b1;
			d.val = t[DIGIT_WIDTH-1:0];
		end else if (l >= CH_LOWER_A && l <= CH_LOWER_F) begin
			t     = l - CH_LOWER_A + HEX_LETTER_BIAS;
			d.ok  = 1'b1;
			d.val = t[DIGIT_WIDTH-1:0];
		end
		return d;
	endfunction

endpackage

@@ hdl/aip_char_if.sv @@
`timescale 1ns / 1ps

interface aip_char_if import aip_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CHAR_WIDTH-1:0] char_in;
	logic                  start_flag;

	modport source (output valid, output char_in, output start_flag, input ready);
	modport sink   (input valid, input char_in, input start_flag, output ready);
endinterface

@@ hdl/aip_result_if.sv @@
`timescale 1ns / 1ps

interface aip_result_if import aip_pkg::*; #(
	parameter int unsigned VALUE_WIDTH  = DEF_VALUE_WIDTH,
	parameter int unsigned OFFSET_WIDTH = DEF_OFFSET_WIDTH
) ();
	logic                    valid;
	logic                    ready;
	logic [VALUE_WIDTH-1:0]  number;
	logic [OFFSET_WIDTH-1:0] end_offset;

	modport source (output valid, output number, output end_offset, input ready);
	modport sink   (input valid, input number, input end_offset, output ready);
endinterface

@@ hdl/aip_step.sv @@
`timescale 1ns / 1ps

module aip_step import aip_pkg::*; #(
	parameter int unsigned VALUE_WIDTH  = DEF_VALUE_WIDTH,
	parameter int unsigned OFFSET_WIDTH = DEF_OFFSET_WIDTH
) (
	input  logic [CHAR_WIDTH-1:0]   chr,
	input  logic                    start,
	input  logic [RADIX_WIDTH-1:0]  radix,
	input  logic [MODE_WIDTH-1:0]   mode,
	input  phase_t                  phase_q,
	input  logic [VALUE_WIDTH-1:0]  accum_q,
	input  logic [RADIX_WIDTH-1:0]  base_q,
	input  logic                    neg_q,
	input  logic [OFFSET_WIDTH:0]   count_q,
	output phase_t                  phase_d,
	output logic [VALUE_WIDTH-1:0]  accum_d,
	output logic [RADIX_WIDTH-1:0]  base_d,
	output logic                    neg_d,
	output logic [OFFSET_WIDTH:0]   count_d,
	output logic                    emit,
	output logic [VALUE_WIDTH-1:0]  number,
	output logic [OFFSET_WIDTH-1:0] end_offset
);

	localparam logic [OFFSET_WIDTH+1:0] OFF_MAX = {2'b00, {OFFSET_WIDTH{1'b1}}};

	phase_t                     ph_c;
	logic [VALUE_WIDTH-1:0]     acc_c;
	logic [RADIX_WIDTH-1:0]     base_c;
	logic                       neg_c;
	logic [OFFSET_WIDTH:0]      cnt_c;
	logic                       sign_take;
	logic [CHAR_WIDTH-1:0]      low_c;
	digit_t                     dv;
	logic [SHIFT_WIDTH-1:0]     sh;
	logic                       take;
	logic                       take_dig;
	logic                       take_suf;
	logic                       fire;
	end_sel_t                   end_sel;
	logic [VALUE_WIDTH+RADIX_WIDTH-1:0] prod;
	logic [OFFSET_WIDTH+1:0]    end_raw;

	// a start beat restarts the string state
	assign ph_c   = start ? PH_FIRST : phase_q;
	assign acc_c  = start ? '0 : accum_q;
	assign base_c = start ? radix : base_q;
	assign neg_c  = start ? 1'b0 : neg_q;
	assign cnt_c  = start ? '0 : count_q;

	assign sign_take = start && (mode == MODE_SIGNED) && (chr == CH_MINUS);
	assign low_c     = to_lower(chr);
	assign dv        = digit_of(chr);

	// size suffix decode
	always_comb begin
		sh = SHIFT_NONE;
		if (mode == MODE_SUFFIX) begin
			if (low_c == CH_LOWER_K) begin
				sh = SHIFT_KILO;
			end else if (low_c == CH_LOWER_M) begin
				sh = SHIFT_MEGA;
			end else if (low_c == CH_LOWER_G) begin
				sh = SHIFT_GIGA;
			end
		end
	end

	// next phase and base, and what this character does
	always_comb begin
		phase_d  = ph_c;
		base_d   = base_c;
		take     = 1'b0;
		take_dig = 1'b0;
		take_suf = 1'b0;
		fire     = 1'b0;
		end_sel  = END_AT;
		case (ph_c)
			PH_IDLE: begin
				phase_d = PH_IDLE;
			end
			PH_FIRST: begin
				if (sign_take) begin
					phase_d = PH_FIRST;
				end else if (chr == CH_ZERO && (base_c == BASE_AUTO || base_c == BASE_HEX)) begin
					phase_d = PH_ZERO;
				end else begin
					base_d = (base_c == BASE_AUTO) ? BASE_DEC : base_c;
					take   = 1'b1;
				end
			end
			PH_ZERO: begin
				if (low_c == CH_LOWER_X) begin
					phase_d = (base_c == BASE_AUTO) ? PH_ZEROX : PH_DIGITS;
				end else begin
					base_d = (base_c == BASE_AUTO) ? BASE_OCT : base_c;
					take   = 1'b1;
				end
			end
			PH_ZEROX: begin
				if (dv.ok) begin
					base_d = BASE_HEX;
					take   = 1'b1;
				end else begin
					// "0x" with no hex digit: octal zero ending after the '0'
					base_d  = BASE_OCT;
					fire    = 1'b1;
					end_sel = END_BEFORE;
				end
			end
			PH_DIGITS: begin
				take = 1'b1;
			end
			PH_SUF1: begin
				if (chr == CH_LOWER_I) begin
					phase_d = PH_SUF2;
				end else begin
					fire    = 1'b1;
					end_sel = (chr == CH_UPPER_B) ? END_AFTER : END_AT;
				end
			end
			PH_SUF2: begin
				fire    = 1'b1;
				end_sel = (chr == CH_UPPER_B) ? END_AFTER : END_AT;
			end
			default: begin
				phase_d = PH_IDLE;
			end
		endcase
		// digit, suffix or end of number
		if (take) begin
			if (dv.ok && ({1'b0, dv.val} < base_d)) begin
				take_dig = 1'b1;
				phase_d  = PH_DIGITS;
			end else if (sh != SHIFT_NONE) begin
				take_suf = 1'b1;
				phase_d  = PH_SUF1;
			end else begin
				fire = 1'b1;
			end
		end
		if (fire) begin
			phase_d = PH_IDLE;
		end
	end

	assign prod = {{RADIX_WIDTH{1'b0}}, acc_c} * {{VALUE_WIDTH{1'b0}}, base_d};

	// datapath and result
	always_comb begin
		accum_d = acc_c;
		if (take_dig) begin
			accum_d = prod[VALUE_WIDTH-1:0] + {{(VALUE_WIDTH-DIGIT_WIDTH){1'b0}}, dv.val};
		end else if (take_suf) begin
			accum_d = acc_c << sh;
		end

		neg_d = sign_take ? 1'b1 : neg_c;

		if (ph_c == PH_IDLE) begin
			count_d = count_q;
		end else if (sign_take) begin
			count_d = {{OFFSET_WIDTH{1'b0}}, 1'b1};
		end else if (cnt_c[OFFSET_WIDTH]) begin
			count_d = cnt_c;
		end else begin
			count_d = cnt_c + 1'b1;
		end

		emit   = fire;
		number = neg_c ? ({VALUE_WIDTH{1'b0}} - acc_c) : acc_c;

		case (end_sel)
			END_AT:     end_raw = {1'b0, cnt_c};
			END_BEFORE: end_raw = {1'b0, cnt_c} - 1'b1;
			END_AFTER:  end_raw = {1'b0, cnt_c} + 1'b1;
			default:    end_raw = {1'b0, cnt_c};
		endcase
		end_offset = (end_raw > OFF_MAX) ? OFF_MAX[OFFSET_WIDTH-1:0] : end_raw[OFFSET_WIDTH-1:0];
	end

endmodule

@@ hdl/aip_out_buf.sv @@
`timescale 1ns / 1ps

module aip_out_buf import aip_pkg::*; #(
	parameter int unsigned VALUE_WIDTH  = DEF_VALUE_WIDTH,
	parameter int unsigned OFFSET_WIDTH = DEF_OFFSET_WIDTH
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    load,
	input  logic [VALUE_WIDTH-1:0]  number_d,
	input  logic [OFFSET_WIDTH-1:0] offset_d,
	output logic                    can_load,
	aip_result_if.source            result
);

	logic                    valid_q;
	logic [VALUE_WIDTH-1:0]  number_q;
	logic [OFFSET_WIDTH-1:0] offset_q;

	// free when empty or when the held beat leaves this cycle
	assign can_load = !valid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (result.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			number_q <= number_d;
			offset_q <= offset_d;
		end
	end

	assign result.valid      = valid_q;
	assign result.number     = number_q;
	assign result.end_offset = offset_q;

endmodule

@@ hdl/ascii_integer_parser.sv @@
`timescale 1ns / 1ps
// Path: the character beat that ends the number passes the input register, then the parse
// step into the result register, which offers the result beat.
// Throughput: one character per cycle, limited only by the single step between the
// input register and the parser state; stalls only while a result waits unaccepted.
// Reset: arst_n clears the parser to idle, both registers to 0 and empties both stages.
module ascii_integer_parser import aip_pkg::*; #(
	parameter int unsigned VALUE_WIDTH  = DEF_VALUE_WIDTH,
	parameter int unsigned OFFSET_WIDTH = DEF_OFFSET_WIDTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
	input  logic [CFG_DATA_WIDTH-1:0]  cfg_data,
	aip_char_if.sink                   char_chan,
	aip_result_if.source               result_chan
);

	logic [RADIX_WIDTH-1:0]  radix_q;
	logic [MODE_WIDTH-1:0]   mode_q;

	logic                    valid_s1;
	logic [CHAR_WIDTH-1:0]   char_s1;
	logic                    start_s1;

	phase_t                  phase_q;
	logic [VALUE_WIDTH-1:0]  accum_q;
	logic [RADIX_WIDTH-1:0]  base_q;
	logic                    neg_q;
	logic [OFFSET_WIDTH:0]   count_q;

	phase_t                  phase_d;
	logic [VALUE_WIDTH-1:0]  accum_d;
	logic [RADIX_WIDTH-1:0]  base_d;
	logic                    neg_d;
	logic [OFFSET_WIDTH:0]   count_d;
	logic                    emit;
	logic [VALUE_WIDTH-1:0]  number_d;
	logic [OFFSET_WIDTH-1:0] offset_d;

	logic                    can_load;
	logic                    advance;
	logic                    accept;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= BASE_AUTO;
			mode_q  <= MODE_UNSIGNED;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_RADIX: radix_q <= cfg_data[RADIX_WIDTH-1:0];
				REG_MODE:  mode_q  <= cfg_data[MODE_WIDTH-1:0];
				default:   radix_q <= radix_q;
			endcase
		end
	end

	// input register stage
	assign advance        = valid_s1 && can_load;
	assign char_chan.ready = !valid_s1 || can_load;
	assign accept         = char_chan.valid && char_chan.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			char_s1  <= char_chan.char_in;
			start_s1 <= char_chan.start_flag;
		end
	end

	// parse step
	aip_step #(
		.VALUE_WIDTH  (VALUE_WIDTH),
		.OFFSET_WIDTH (OFFSET_WIDTH)
	) u_step (
		.chr        (char_s1),
		.start      (start_s1),
		.radix      (radix_q),
		.mode       (mode_q),
		.phase_q    (phase_q),
		.accum_q    (accum_q),
		.base_q     (base_q),
		.neg_q      (neg_q),
		.count_q    (count_q),
		.phase_d    (phase_d),
		.accum_d    (accum_d),
		.base_d     (base_d),
		.neg_d      (neg_d),
		.count_d    (count_d),
		.emit       (emit),
		.number     (number_d),
		.end_offset (offset_d)
	);

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			accum_q <= '0;
			base_q  <= BASE_AUTO;
			neg_q   <= 1'b0;
			count_q <= '0;
		end else if (advance) begin
			phase_q <= phase_d;
			accum_q <= accum_d;
			base_q  <= base_d;
			neg_q   <= neg_d;
			count_q <= count_d;
		end
	end

	// result register
	aip_out_buf #(
		.VALUE_WIDTH  (VALUE_WIDTH),
		.OFFSET_WIDTH (OFFSET_WIDTH)
	) u_out_buf (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (advance && emit),
		.number_d (number_d),
		.offset_d (offset_d),
		.can_load (can_load),
		.result   (result_chan)
	);

	// a result beat only appears after a parse step
	a_result_from_step: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_chan.valid) |-> $past(advance))
		else $error("result beat without a parse step");

	// the second suffix phase is only entered from the first
	a_suffix_order: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_SUF2 && $past(phase_q) != PH_SUF2) |-> $past(phase_q) == PH_SUF1)
		else $error("suffix phase entered out of order");

	// digits are only collected once a base is fixed
	a_base_fixed: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_DIGITS) |-> (base_q != BASE_AUTO))
		else $error("collecting digits without a base");

	// character count stops one past the largest offset
	a_count_sat: assert property (@(posedge clk) disable iff (!arst_n)
		count_q[OFFSET_WIDTH] |-> (count_q[OFFSET_WIDTH-1:0] == '0))
		else $error("character count ran past saturation");

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
	import aip_pkg::*;

	localparam int unsigned WATCHDOG_LIMIT = 2000;
	localparam int unsigned SETTLE_CYCLES  = 4;
	localparam int unsigned NOT_HEX        = 256;
	localparam int unsigned LONG_RUN       = 40;

	localparam logic [DEF_OFFSET_WIDTH-1:0] OFFSET_SAT = '1;
	// mode 3 has no meaning of its own and parses as unsigned
	localparam logic [MODE_WIDTH-1:0] MODE_SPARE  = 2'd3;
	localparam logic [CHAR_WIDTH-1:0] CH_NUL      = 8'h00;
	localparam logic [CHAR_WIDTH-1:0] CH_SPACE    = 8'h20;
	localparam logic [CHAR_WIDTH-1:0] CH_ALL_ONES = 8'hff;

	typedef struct packed {
		logic [DEF_VALUE_WIDTH-1:0]  number;
		logic [DEF_OFFSET_WIDTH-1:0] end_offset;
	} parsed_num_t;

	logic                       clk;
	logic                       arst_n;
	logic                       cfg_we;
	logic [CFG_INDEX_WIDTH-1:0] cfg_index;
	logic [CFG_DATA_WIDTH-1:0]  cfg_data;

	aip_char_if   char_chan ();
	aip_result_if result_chan ();

	ascii_integer_parser dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.char_chan   (char_chan),
		.result_chan (result_chan)
	);

	// parser copy: registers and string state
	logic [RADIX_WIDTH-1:0]     radix_m;
	logic [MODE_WIDTH-1:0]      mode_m;
	phase_t                     phase_m;
	logic [DEF_VALUE_WIDTH-1:0] accum_m;
	logic [RADIX_WIDTH-1:0]     base_m;
	bit                         neg_m;
	int unsigned                count_m;

	parsed_num_t expected_nums[$];
	int          err_count;
	int unsigned chars_sent;
	int unsigned idle_cycles;
	int unsigned hold_left;
	bit          gaps_on;
	bit          stalls_on;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// gap length: mostly none, some short, a few long
	function automatic int unsigned idle_len(input bit on);
		int unsigned r;
		r = $urandom_range(99);
		if (!on || r < 65) return 0;
		if (r < 93) return $urandom_range(3, 1);
		return $urandom_range(32, 8);
	endfunction

	function automatic logic [CHAR_WIDTH-1:0] fold_case(input logic [CHAR_WIDTH-1:0] c);
		if (c >= CH_UPPER_A && c <= CH_UPPER_Z) return c + CASE_GAP;
		return c;
	endfunction

	function automatic int unsigned hex_value(input logic [CHAR_WIDTH-1:0] c);
		logic [CHAR_WIDTH-1:0] l;
		l = fold_case(c);
		if (l >= CH_ZERO && l <= CH_NINE) return 32'(l - CH_ZERO);
		if (l >= CH_LOWER_A && l <= CH_LOWER_F) return 32'(l - CH_LOWER_A) + 10;
		return NOT_HEX;
	endfunction

	task automatic note_error(input string what, input logic [63:0] want, input logic [63:0] got);
		err_count++;
		if (err_count <= 10)
			$display("mismatch in %s: expected %0h, got %0h", what, want, got);
	endtask

	task automatic reset_parser_copy();
		radix_m = BASE_AUTO;
		mode_m  = MODE_UNSIGNED;
		phase_m = PH_IDLE;
		accum_m = '0;
		base_m  = '0;
		neg_m   = 1'b0;
		count_m = 0;
	endtask

	task automatic close_number(input int unsigned pos);
		parsed_num_t r;
		r.number     = neg_m ? ('0 - accum_m) : accum_m;
		r.end_offset = (pos > OFFSET_SAT) ? OFFSET_SAT : pos[DEF_OFFSET_WIDTH-1:0];
		expected_nums.push_back(r);
		phase_m = PH_IDLE;
	endtask

	// one digit, a size suffix, or the end of the number
	task automatic take_digit(input logic [CHAR_WIDTH-1:0] c, input int unsigned pos);
		int unsigned           v;
		logic [CHAR_WIDTH-1:0] l;
		logic [SHIFT_WIDTH-1:0] sh;
		v  = hex_value(c);
		l  = fold_case(c);
		sh = SHIFT_NONE;
		if (v < base_m) begin
			accum_m = accum_m * base_m + v;
			return;
		end
		if (mode_m == MODE_SUFFIX) begin
			if (l == CH_LOWER_K) sh = SHIFT_KILO;
			else if (l == CH_LOWER_M) sh = SHIFT_MEGA;
			else if (l == CH_LOWER_G) sh = SHIFT_GIGA;
			if (sh != SHIFT_NONE) begin
				accum_m = accum_m << sh;
				phase_m = PH_SUF1;
				return;
			end
		end
		close_number(pos);
	endtask

	// expected effect of one accepted character beat
	task automatic parse_char(input logic [CHAR_WIDTH-1:0] c, input logic st);
		int unsigned pos;
		if (st) begin
			accum_m = '0;
			neg_m   = 1'b0;
			base_m  = radix_m;
			count_m = 0;
			phase_m = PH_FIRST;
			if (mode_m == MODE_SIGNED && c == CH_MINUS) begin
				neg_m   = 1'b1;
				count_m = 1;
				return;
			end
		end else if (phase_m == PH_IDLE) begin
			return;
		end
		pos = count_m;
		if (count_m <= OFFSET_SAT) count_m++;
		case (phase_m)
			PH_FIRST: begin
				if (c == CH_ZERO && (base_m == BASE_AUTO || base_m == BASE_HEX)) begin
					phase_m = PH_ZERO;
				end else begin
					if (base_m == BASE_AUTO) base_m = BASE_DEC;
					phase_m = PH_DIGITS;
					take_digit(c, pos);
				end
			end
			PH_ZERO: begin
				if (fold_case(c) == CH_LOWER_X) begin
					if (base_m == BASE_AUTO) begin
						phase_m = PH_ZEROX;
					end else begin
						accum_m = '0;
						phase_m = PH_DIGITS;
					end
				end else begin
					if (base_m == BASE_AUTO) base_m = BASE_OCT;
					accum_m = '0;
					phase_m = PH_DIGITS;
					take_digit(c, pos);
				end
			end
			PH_ZEROX: begin
				// "0x" counts as hex only when a hex digit follows
				if (hex_value(c) < 16) begin
					base_m  = BASE_HEX;
					phase_m = PH_DIGITS;
					take_digit(c, pos);
				end else begin
					base_m  = BASE_OCT;
					accum_m = '0;
					close_number(pos - 1);
				end
			end
			PH_DIGITS: take_digit(c, pos);
			PH_SUF1: begin
				if (c == CH_LOWER_I) phase_m = PH_SUF2;
				else close_number(c == CH_UPPER_B ? pos + 1 : pos);
			end
			PH_SUF2: close_number(c == CH_UPPER_B ? pos + 1 : pos);
			default: phase_m = PH_IDLE;
		endcase
	endtask

	// one character beat, after a random gap
	task automatic send_char(input logic [CHAR_WIDTH-1:0] c, input logic st);
		int unsigned gap;
		gap = idle_len(gaps_on);
		if (gap != 0) begin
			char_chan.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		char_chan.valid      <= 1'b1;
		char_chan.char_in    <= c;
		char_chan.start_flag <= st;
		@(posedge clk);
		while (!char_chan.ready) @(posedge clk);
		parse_char(c, st);
		chars_sent++;
	endtask

	task automatic send_text(input string s, input logic [CHAR_WIDTH-1:0] term);
		for (int i = 0; i < s.len(); i++) send_char(s[i], i == 0);
		send_char(term, s.len() == 0);
	endtask

	// hold the sender until every expected number is back and the pipe is empty
	task automatic wait_results_drained();
		char_chan.valid <= 1'b0;
		while (expected_nums.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
			input logic [CFG_DATA_WIDTH-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_RADIX) radix_m = val;
		else mode_m = val[MODE_WIDTH-1:0];
	endtask

	task automatic set_config(input logic [RADIX_WIDTH-1:0] radix, input logic [MODE_WIDTH-1:0] mode);
		wait_results_drained();
		write_reg(REG_RADIX, radix);
		write_reg(REG_MODE, CFG_DATA_WIDTH'(mode));
	endtask

	// digit character that is mostly valid for base b, in random case
	function automatic logic [CHAR_WIDTH-1:0] digit_char(input int unsigned b);
		int unsigned v;
		if (b <= 1) v = 0;
		else if (b > 16) v = $urandom_range(15);
		else v = $urandom_range(b - 1);
		if ($urandom_range(9) == 0) v = $urandom_range(15);
		if (v < 10) return CH_ZERO + CHAR_WIDTH'(v);
		return ($urandom_range(1) ? CH_LOWER_A : CH_UPPER_A) + CHAR_WIDTH'(v - 10);
	endfunction

	task automatic send_random_string();
		logic [CHAR_WIDTH-1:0] text_q[$];
		logic [CHAR_WIDTH-1:0] sfx;
		int unsigned           kind;
		int unsigned           b;
		int unsigned           ndig;
		bit                    first_start;
		kind        = $urandom_range(99);
		b           = (radix_m == BASE_AUTO) ? BASE_DEC : radix_m;
		first_start = 1'b1;
		if (kind < 75) begin
			// well-formed: sign, prefix, digits, suffix, terminator
			if ($urandom_range(3) == 0) text_q.push_back(CH_MINUS);
			case ($urandom_range(5))
				0: begin
					text_q.push_back(CH_ZERO);
					text_q.push_back($urandom_range(1) ? CH_LOWER_X : CH_LOWER_X - CASE_GAP);
					if (radix_m == BASE_AUTO) b = BASE_HEX;
				end
				1: begin
					text_q.push_back(CH_ZERO);
					if (radix_m == BASE_AUTO) b = BASE_OCT;
				end
				default: ;
			endcase
			ndig = ($urandom_range(9) == 0) ? $urandom_range(24, 10) : $urandom_range(5, 1);
			repeat (ndig) text_q.push_back(digit_char(b));
			if ($urandom_range(2) == 0) begin
				case ($urandom_range(2))
					0: sfx = CH_LOWER_K;
					1: sfx = CH_LOWER_M;
					default: sfx = CH_LOWER_G;
				endcase
				text_q.push_back($urandom_range(1) ? sfx : sfx - CASE_GAP);
				if ($urandom_range(1)) text_q.push_back(CH_LOWER_I);
				if ($urandom_range(1)) text_q.push_back(CH_UPPER_B);
			end
			case ($urandom_range(3))
				0: text_q.push_back(CH_NUL);
				1: text_q.push_back(CH_SPACE);
				2: text_q.push_back(CH_ALL_ONES);
				default: text_q.push_back(CHAR_WIDTH'($urandom_range(255)));
			endcase
		end else if (kind < 92) begin
			// noise, sometimes with no start mark at all
			first_start = ($urandom_range(1) != 0);
			repeat ($urandom_range(6, 1)) text_q.push_back(CHAR_WIDTH'($urandom_range(255)));
		end else begin
			// unfinished string, abandoned by whatever starts next
			repeat ($urandom_range(4, 1)) text_q.push_back(digit_char(b));
		end
		foreach (text_q[i])
			send_char(text_q[i], i == 0 ? first_start : ($urandom_range(15) == 0));
	endtask

	task automatic test_idle_chars();
		// reset state: nothing started, so the lone characters are dropped until a string starts
		send_char(CH_ALL_ONES, 1'b0);
		send_char(CH_ZERO + 8'd5, 1'b0);
		send_char(CH_NUL, 1'b0);
		send_text("0x1f", CH_NUL);
	endtask

	task automatic test_auto_radix();
		set_config(BASE_AUTO, MODE_UNSIGNED);
		send_text("017", CH_NUL);
		send_text("0xg", CH_NUL);
		send_text("0X", CH_NUL);
		send_text("0", CH_NUL);
		send_text("08", CH_SPACE);
		send_text("89", CH_ALL_ONES);
		send_text("", CH_NUL);
	endtask

	task automatic test_value_extremes();
		set_config(BASE_DEC, MODE_UNSIGNED);
		send_text("18446744073709551615", CH_ALL_ONES);
		send_text("18446744073709551616", CH_NUL);
		set_config(BASE_HEX, MODE_SPARE);
		send_text("0xFFFFFFFFFFFFFFFF", CH_NUL);
		send_text("fedcba9876543210ab", CH_SPACE);
		send_text("-5", CH_NUL);
	endtask

	task automatic test_odd_radix();
		set_config(5'd1, MODE_UNSIGNED);
		send_text("0001", CH_NUL);
		set_config(5'd2, MODE_UNSIGNED);
		send_text("1012", CH_NUL);
		set_config(5'd17, MODE_UNSIGNED);
		send_text("ffg", CH_NUL);
		set_config(5'd31, MODE_UNSIGNED);
		send_text("Ff0", CH_NUL);
	endtask

	task automatic test_signed();
		set_config(BASE_DEC, MODE_SIGNED);
		send_text("-123", CH_NUL);
		send_text("-", CH_NUL);
		send_text("--5", CH_NUL);
		set_config(BASE_HEX, MODE_SIGNED);
		send_text("-0x10", CH_NUL);
	endtask

	task automatic test_size_suffix();
		set_config(BASE_AUTO, MODE_SUFFIX);
		send_text("4k", CH_NUL);
		send_text("4KiB", CH_NUL);
		send_text("3mB", CH_SPACE);
		send_text("2Gi", CH_ALL_ONES);
		send_text("1gb", CH_NUL);
		send_text("0x1bk", CH_NUL);
	endtask

	task automatic test_restart();
		set_config(BASE_DEC, MODE_UNSIGNED);
		send_char(CH_ZERO + 8'd1, 1'b1);
		send_char(CH_ZERO + 8'd2, 1'b0);
		send_text("34", CH_NUL);
	endtask

	task automatic test_mode_change_mid_string();
		// sign taken under signed mode survives the switch to suffix mode
		set_config(BASE_DEC, MODE_SIGNED);
		send_char(CH_MINUS, 1'b1);
		send_char(CH_ZERO + 8'd1, 1'b0);
		send_char(CH_ZERO + 8'd2, 1'b0);
		wait_results_drained();
		write_reg(REG_MODE, CFG_DATA_WIDTH'(MODE_SUFFIX));
		send_char(CH_LOWER_K, 1'b0);
		send_char(CH_NUL, 1'b0);
	endtask

	// long digit run back to back, wrapping the value
	task automatic test_long_number();
		set_config(BASE_DEC, MODE_UNSIGNED);
		gaps_on = 1'b0;
		send_char(CH_ZERO + 8'd7, 1'b1);
		repeat (LONG_RUN - 1) send_char(CH_ZERO + 8'd7, 1'b0);
		send_char(CH_NUL, 1'b0);
		gaps_on = 1'b1;
	endtask

	task automatic test_random_strings();
		int unsigned            target;
		logic [RADIX_WIDTH-1:0] pick;
		for (int p = 0; p < 9; p++) begin
			case (p)
				0: pick = BASE_AUTO;
				1: pick = BASE_DEC;
				2: pick = BASE_HEX;
				3: pick = BASE_OCT;
				4: pick = 5'd1;
				5: pick = 5'd2;
				6: pick = 5'd17;
				7: pick = 5'd31;
				default: pick = RADIX_WIDTH'($urandom_range(31));
			endcase
			set_config(pick, MODE_WIDTH'(p % 4));
			gaps_on   = (p % 4 != 3);
			stalls_on = (p % 3 != 2);
			target    = chars_sent + 35;
			while (chars_sent < target) begin
				send_random_string();
				if ($urandom_range(19) == 0) wait_results_drained();
			end
		end
		gaps_on   = 1'b1;
		stalls_on = 1'b1;
	endtask

	// result side back-pressure
	always @(posedge clk) begin
		if (!arst_n) begin
			result_chan.ready <= 1'b0;
		end else if (hold_left != 0) begin
			result_chan.ready <= 1'b0;
			hold_left--;
		end else begin
			result_chan.ready <= 1'b1;
			hold_left = idle_len(stalls_on);
		end
	end

	// compare each result beat with the oldest expected number
	always @(posedge clk) begin
		parsed_num_t want;
		if (arst_n && result_chan.valid && result_chan.ready) begin
			if (expected_nums.size() == 0) begin
				note_error("unexpected result", '0, result_chan.number);
			end else begin
				want = expected_nums.pop_front();
				if (result_chan.number !== want.number)
					note_error("number", want.number, result_chan.number);
				if (result_chan.end_offset !== want.end_offset)
					note_error("end_offset", 64'(want.end_offset),
						64'(result_chan.end_offset));
			end
		end
	end

	// watchdog on cycles with no beat on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((char_chan.valid && char_chan.ready) || (result_chan.valid && result_chan.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("testbench: done, errors");
				$finish;
			end
		end
	end

	initial begin
		arst_n               <= 1'b0;
		cfg_we               <= 1'b0;
		cfg_index            <= '0;
		cfg_data             <= '0;
		char_chan.valid      <= 1'b0;
		char_chan.char_in    <= '0;
		char_chan.start_flag <= 1'b0;
		err_count   = 0;
		chars_sent  = 0;
		idle_cycles = 0;
		hold_left   = 0;
		gaps_on     = 1'b1;
		stalls_on   = 1'b1;
		reset_parser_copy();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_idle_chars();
		test_auto_radix();
		test_value_extremes();
		test_odd_radix();
		test_signed();
		test_size_suffix();
		test_restart();
		test_mode_change_mid_string();
		test_long_number();
		test_random_strings();

		wait_results_drained();
		repeat (8) @(posedge clk);
		if (expected_nums.size() != 0) begin
			err_count += expected_nums.size();
			$display("%0d expected results never arrived", expected_nums.size());
		end
		if (err_count == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule

@@ files.f @@
hdl/aip_pkg.sv
hdl/aip_char_if.sv
hdl/aip_result_if.sv
hdl/aip_step.sv
hdl/aip_out_buf.sv
hdl/ascii_integer_parser.sv
sim/testbench.sv
